// ----- hw/rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared command codes, status codes and control structs for the deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// Field widths fixed by the interface.
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_VIEW       = 3'd5;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic single;     // execute a one-result command this cycle
		logic view_load;  // load the view walker from front and count
		logic view_read;  // read one entry and emit it
	} bdq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;      // queue holds no entries
		logic view_last;  // the entry read this cycle is the back entry
	} bdq_stat_t;

endpackage

// ----- hw/rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: accepts items and sequences the view walk over the ring.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] cmd,
	input  bdq_stat_t        dp_stat,
	output bdq_cmd_t         dp_cmd,
	output logic             busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_VIEW = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;
	logic is_walk;

	assign busy    = (state_q == ST_VIEW);
	assign accept  = start && !busy;
	// A view of a non-empty queue walks the ring; everything else is one result.
	assign is_walk = (cmd == CMD_VIEW) && !dp_stat.empty;

	// Command decode and next state.
	always_comb begin
		dp_cmd.single    = 1'b0;
		dp_cmd.view_load = 1'b0;
		dp_cmd.view_read = 1'b0;
		state_d          = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_walk) begin
						dp_cmd.view_load = 1'b1;
						state_d          = ST_VIEW;
					end else begin
						dp_cmd.single = 1'b1;
					end
				end
			end
			ST_VIEW: begin
				dp_cmd.view_read = 1'b1;
				if (dp_stat.view_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/bdq_dp.sv -----
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: ring store, front index, entry count, view walker and result
// registers.
// ----------------------------------------------------------------------------
module bdq_dp import bdq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bdq_cmd_t                     dp_cmd,
	input  logic [CMD_W-1:0]             cmd,
	input  logic signed [DATA_WIDTH-1:0] value,
	output bdq_stat_t                    dp_stat,
	output logic                         done,
	output logic [STATUS_W-1:0]          status,
	output logic                         empty_flag,
	output logic signed [DATA_WIDTH-1:0] data,
	output logic                         last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic [IW-1:0]       front_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       ptr_q;
	logic [CW-1:0]       left_q;

	logic                done_s1;
	logic                view_s1;
	logic                last_s1;
	logic [STATUS_W-1:0] status_s1;

	logic                empty;
	logic                full;
	logic [SW-1:0]       back_sum;
	logic [IW-1:0]       back_addr;
	logic [IW-1:0]       front_dec;
	logic [IW-1:0]       front_inc;
	logic [IW-1:0]       ptr_inc;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;

	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	assign dp_stat.empty     = empty;
	assign dp_stat.view_last = (left_q == CW'(1));

	// Ring index arithmetic; every sum stays below twice the depth.
	always_comb begin
		back_sum  = SW'(front_q) + SW'(count_q);
		back_addr = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);
		front_dec = (front_q == '0) ? LAST_IDX : front_q - IW'(1);
		front_inc = (front_q == LAST_IDX) ? '0 : front_q + IW'(1);
		ptr_inc   = (ptr_q == LAST_IDX) ? '0 : ptr_q + IW'(1);
	end

	// Store write port, used by pushes that find room.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = back_addr;
		if (dp_cmd.single && !full) begin
			if (cmd == CMD_PUSH_BACK) begin
				wr_en = 1'b1;
			end else if (cmd == CMD_PUSH_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = front_dec;
			end
		end
	end

	// Ring store with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		if (dp_cmd.view_read) begin
			rd_q <= mem[ptr_q];
		end
	end

	// Front index and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (dp_cmd.single) begin
			case (cmd)
				CMD_PUSH_BACK: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end
				CMD_PUSH_FRONT: begin
					if (!full) begin
						front_q <= front_dec;
						count_q <= count_q + CW'(1);
					end
				end
				CMD_POP_BACK: begin
					if (!empty) begin
						count_q <= count_q - CW'(1);
					end
				end
				CMD_POP_FRONT: begin
					if (!empty) begin
						front_q <= front_inc;
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// View walker: position in the ring and entries still to emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			left_q <= '0;
		end else if (dp_cmd.view_load) begin
			ptr_q  <= front_q;
			left_q <= count_q;
		end else if (dp_cmd.view_read) begin
			ptr_q  <= ptr_inc;
			left_q <= left_q - CW'(1);
		end
	end

	// Result stage: one strobe per item, or one per entry during a view.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1   <= 1'b0;
			view_s1   <= 1'b0;
			last_s1   <= 1'b0;
			status_s1 <= ST_OK;
		end else begin
			done_s1   <= dp_cmd.single || dp_cmd.view_read;
			view_s1   <= dp_cmd.view_read;
			last_s1   <= dp_cmd.single || (left_q == CW'(1));
			status_s1 <= ST_OK;
			if (dp_cmd.single) begin
				case (cmd) inside
					CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
						if (full) begin
							status_s1 <= ST_FULL;
						end
					end
					CMD_POP_BACK, CMD_POP_FRONT, CMD_VIEW: begin
						if (empty) begin
							status_s1 <= ST_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The count register already holds the state after the reported command.
	assign done       = done_s1;
	assign status     = status_s1;
	assign last       = last_s1;
	assign empty_flag = empty;
	assign data       = view_s1 ? rd_q : '0;

endmodule

// ----- hw/rtl/bounded_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed values in a ring store, with a command interface.
// ----------------------------------------------------------------------------
//
// Channel   Handshake           Payload
// -------   -----------------   ----------------------------------
// command   start, busy         cmd, value
// result    done (one cycle)    status, empty_flag, data, last
//
// A command is taken on a clock edge with start high and busy low; its single
// result is registered and shows in the next cycle, so a new command may follow every cycle while busy is low.
// A view of N stored entries raises busy while it walks the ring and emits N results on
// consecutive cycles, from one store read per cycle (single read port).
// Reset empties the queue at once; the store needs no clearing pass.
// The receiver cannot stall; each result is valid for exactly one cycle.
//
module bounded_double_ended_queue import bdq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [CMD_W-1:0]             cmd,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         done,
	output logic [STATUS_W-1:0]          status,
	output logic                         empty_flag,
	output logic signed [DATA_WIDTH-1:0] data,
	output logic                         last
);

	bdq_cmd_t  dp_cmd;
	bdq_stat_t dp_stat;

	// Sequencer.
	bdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.dp_stat (dp_stat),
		.dp_cmd  (dp_cmd),
		.busy    (busy)
	);

	// Ring store and result registers.
	bdq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.cmd        (cmd),
		.value      (value),
		.dp_stat    (dp_stat),
		.done       (done),
		.status     (status),
		.empty_flag (empty_flag),
		.data       (data),
		.last       (last)
	);

endmodule

// ----- hw/rtl/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the deque's result sequencing.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [CMD_W-1:0]             cmd,
	input logic                         done,
	input logic [STATUS_W-1:0]          status,
	input logic                         empty_flag,
	input logic signed [DATA_WIDTH-1:0] data,
	input logic                         last
);

	// Every command other than view gives its single result on the next cycle.
	a_single_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd != CMD_VIEW) |=> (done && last))
		else $error("single-result command did not finish next cycle");

	// A view burst has no gaps: a result that is not the last is followed by another.
	a_view_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |=> done)
		else $error("view burst broken");

	// Refused commands give one result with zero data.
	a_refused_single: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (last && data == '0))
		else $error("refused command result malformed");

	// A dropped push means the queue is full, so it cannot read as empty.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> !empty_flag)
		else $error("full status with empty flag set");

	// An accepted view result of a non-empty queue never reports empty.
	a_view_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |-> (status == ST_OK && !empty_flag))
		else $error("view entry reported with empty queue");

endmodule

bind bounded_double_ended_queue bdq_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_bdq_checker (.*);
